>>> rtl/htsd_pkg.sv
`default_nettype none

package htsd_pkg;

    // Fixed field widths
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 7;   // holds a code length, saturated to MAX_CODE_LEN
    localparam int BITS_W = 32;
    localparam int BYTE_W = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_SKIP_BITS = 1'b0;   // register index, paddr[2]

    // Item functions
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_SYMBOL  = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic              func;
        logic [SYM_W-1:0]  code_symbol;
        logic [5:0]        code_len;
        logic [BITS_W-1:0] code_bits;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic [1:0]       status;
        logic             last;
    } t_out_item;

    // Classified command as handed from the front to the back
    typedef struct packed {
        logic              is_decode;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  length;
        logic [BITS_W-1:0] bits;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic             load;
        logic [SYM_W-1:0] skip_bits;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/htsd_stream_if.sv
`default_nettype none

interface htsd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/htsd_front.sv
`default_nettype none

module htsd_front #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire htsd_pkg::t_in_item i_data,
    output logic                   o_cmd_valid,
    output htsd_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_pop
);

    localparam logic [htsd_pkg::LEN_W-1:0] MAX_LEN = (htsd_pkg::LEN_W)'(MAX_CODE_LEN);
    localparam logic [htsd_pkg::QPTR_W:0]  FULL_CNT =
        (htsd_pkg::QPTR_W + 1)'(htsd_pkg::QUEUE_DEPTH);

    htsd_pkg::t_cmd r_q [htsd_pkg::QUEUE_DEPTH];
    logic [htsd_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [htsd_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [htsd_pkg::QPTR_W:0]   r_count, n_count;

    logic                         push;
    logic                         pop;
    logic [htsd_pkg::LEN_W-1:0]   len_ext;
    htsd_pkg::t_cmd               cmd_in;

    // classify: decode or load, length saturated
    always_comb begin
        len_ext          = {1'b0, i_data.code_len};
        cmd_in.is_decode = (i_data.func == htsd_pkg::FUNC_DECODE);
        cmd_in.symbol    = i_data.code_symbol;
        cmd_in.length    = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;
        cmd_in.bits      = i_data.code_bits;
        cmd_in.data      = i_data.data_byte;
    end

    assign o_ready     = (r_count != FULL_CNT);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/htsd_back.sv
`default_nettype none

module htsd_back #(
    parameter int NODE_COUNT = 511
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire htsd_pkg::t_cmd     i_cmd,
    output logic                    o_cmd_pop,
    input  wire htsd_pkg::t_cfg     i_cfg,
    output logic                    o_out_valid,
    output htsd_pkg::t_out_item     o_out,
    input  wire logic               i_out_ready
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int USED_W = $clog2(NODE_COUNT + 1);
    localparam logic [USED_W-1:0] NODE_LIMIT = USED_W'(NODE_COUNT);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LWALK  = 3'd1;
    localparam logic [2:0] S_LREAD  = 3'd2;
    localparam logic [2:0] S_DFETCH = 3'd3;
    localparam logic [2:0] S_DSTEP  = 3'd4;
    localparam logic [2:0] S_DREAD  = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    typedef struct packed {
        logic [1:0]                 present;  // bit 0 left, bit 1 right
        logic [NODE_W-1:0]          left;
        logic [NODE_W-1:0]          right;
        logic [htsd_pkg::SYM_W-1:0] symbol;
    } t_node;

    // node store, root kept in flops so it has a defined reset value
    t_node r_mem [NODE_COUNT];
    t_node r_rd;
    t_node r_root, n_root;

    logic [2:0]                  r_state, n_state;
    logic [USED_W-1:0]           r_nodes_used, n_nodes_used;
    logic [NODE_W-1:0]           r_dec_node, n_dec_node;
    logic [htsd_pkg::SYM_W-1:0]  r_skip_left, n_skip_left;
    logic                        r_err_stop, n_err_stop;
    logic                        r_pend_valid, n_pend_valid;
    logic                        r_out_valid, n_out_valid;

    t_node                       r_cur, n_cur;
    logic [NODE_W-1:0]           r_idx, n_idx;
    logic [htsd_pkg::LEN_W-1:0]  r_cnt, n_cnt;
    logic [htsd_pkg::BITS_W-1:0] r_bits, n_bits;
    logic [htsd_pkg::SYM_W-1:0]  r_sym, n_sym;
    logic [htsd_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic [3:0]                  r_bitcnt, n_bitcnt;
    logic [htsd_pkg::SYM_W-1:0]  r_pend_sym, n_pend_sym;
    logic [1:0]                  r_pend_st, n_pend_st;
    htsd_pkg::t_out_item         r_out, n_out;

    logic                        rd_en;
    logic [NODE_W-1:0]           rd_addr;
    logic                        wr_en;
    logic                        mem_wr_en;
    logic [NODE_W-1:0]           wr_idx;
    t_node                       wr_data;

    logic                        out_free;
    logic                        emit_ok;
    logic                        emit;
    logic                        flush;
    logic [htsd_pkg::SYM_W-1:0]  e_sym;
    logic [1:0]                  e_st;

    logic [htsd_pkg::LEN_W-1:0]  pos;
    logic                        lbit;
    logic [NODE_W-1:0]           llink;
    logic                        dbit;
    logic [NODE_W-1:0]           dlink;
    logic [NODE_W-1:0]           new_idx;

    assign out_free = !r_out_valid || i_out_ready;
    assign emit_ok  = !r_pend_valid || out_free;

    // code bit for the load walk; positions past the 32-bit field read as zero
    assign pos   = r_cnt - 1'b1;
    assign lbit  = (pos[htsd_pkg::LEN_W-1:5] == '0) ? r_bits[pos[4:0]] : 1'b0;
    assign llink = lbit ? r_cur.right : r_cur.left;
    assign dbit  = r_byte[htsd_pkg::BYTE_W-1];
    assign dlink = dbit ? r_cur.right : r_cur.left;
    assign new_idx = r_nodes_used[NODE_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_nodes_used = r_nodes_used;
        n_dec_node   = r_dec_node;
        n_skip_left  = r_skip_left;
        n_err_stop   = r_err_stop;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_pend_st    = r_pend_st;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        n_root       = r_root;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_bits       = r_bits;
        n_sym        = r_sym;
        n_byte       = r_byte;
        n_bitcnt     = r_bitcnt;
        o_cmd_pop    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_dec_node;
        wr_en        = 1'b0;
        wr_idx       = r_idx;
        wr_data      = r_cur;
        emit         = 1'b0;
        flush        = 1'b0;
        e_sym        = '0;
        e_st         = htsd_pkg::ST_SYMBOL;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (!i_cmd.is_decode) begin
                        n_cur   = r_root;
                        n_idx   = '0;
                        n_cnt   = i_cmd.length;
                        n_bits  = i_cmd.bits;
                        n_sym   = i_cmd.symbol;
                        n_state = S_LWALK;
                    end else if (!r_err_stop) begin
                        n_byte   = i_cmd.data;
                        n_bitcnt = 4'd8;
                        if (r_dec_node == '0) begin
                            n_cur   = r_root;
                            n_state = S_DSTEP;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_dec_node;
                            n_state = S_DFETCH;
                        end
                    end
                end
            end
            S_LWALK: begin
                if (r_cnt == '0) begin
                    wr_en          = 1'b1;
                    wr_data.symbol = r_sym;
                    n_state        = S_IDLE;
                end else if (r_cur.present[lbit]) begin
                    rd_en   = 1'b1;
                    rd_addr = llink;
                    n_idx   = llink;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_LREAD;
                end else if (r_nodes_used >= NODE_LIMIT) begin
                    if (emit_ok) begin
                        // store the node as it is, allocated nodes stay
                        wr_en   = 1'b1;
                        emit    = 1'b1;
                        e_st    = htsd_pkg::ST_FULL;
                        n_state = S_FLUSH;
                    end
                end else begin
                    wr_en                 = 1'b1;
                    wr_data.present[lbit] = 1'b1;
                    if (lbit) begin
                        wr_data.right = new_idx;
                    end else begin
                        wr_data.left = new_idx;
                    end
                    n_cur        = '0;
                    n_idx        = new_idx;
                    n_nodes_used = r_nodes_used + 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            S_LREAD: begin
                n_cur   = r_rd;
                n_state = S_LWALK;
            end
            S_DFETCH: begin
                n_cur   = r_rd;
                n_state = S_DSTEP;
            end
            S_DSTEP: begin
                if (r_bitcnt == '0) begin
                    n_state = S_FLUSH;
                end else if (r_skip_left != '0) begin
                    n_skip_left = r_skip_left - 1'b1;
                    n_byte      = {r_byte[htsd_pkg::BYTE_W-2:0], 1'b0};
                    n_bitcnt    = r_bitcnt - 1'b1;
                end else if (r_root.present == 2'b00) begin
                    if (emit_ok) begin
                        emit     = 1'b1;
                        e_sym    = r_root.symbol;
                        n_byte   = {r_byte[htsd_pkg::BYTE_W-2:0], 1'b0};
                        n_bitcnt = r_bitcnt - 1'b1;
                    end
                end else if (!r_cur.present[dbit]) begin
                    if (emit_ok) begin
                        emit       = 1'b1;
                        e_st       = htsd_pkg::ST_INVALID;
                        n_err_stop = 1'b1;
                        n_dec_node = '0;
                        n_state    = S_FLUSH;
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = dlink;
                    n_dec_node = dlink;
                    n_byte     = {r_byte[htsd_pkg::BYTE_W-2:0], 1'b0};
                    n_bitcnt   = r_bitcnt - 1'b1;
                    n_state    = S_DREAD;
                end
            end
            S_DREAD: begin
                if (r_rd.present == 2'b00) begin
                    if (emit_ok) begin
                        emit       = 1'b1;
                        e_sym      = r_rd.symbol;
                        n_dec_node = '0;
                        n_cur      = r_root;
                        n_state    = S_DSTEP;
                    end
                end else begin
                    n_cur   = r_rd;
                    n_state = S_DSTEP;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    flush   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a result is held back one step so that the last one can be flagged
        if (emit) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out       = '{out_symbol: r_pend_sym, status: r_pend_st, last: 1'b0};
            end
            n_pend_valid = 1'b1;
            n_pend_sym   = e_sym;
            n_pend_st    = e_st;
        end
        if (flush) begin
            n_out_valid  = 1'b1;
            n_out        = '{out_symbol: r_pend_sym, status: r_pend_st, last: 1'b1};
            n_pend_valid = 1'b0;
        end

        if (wr_en && (wr_idx == '0)) begin
            n_root = wr_data;
        end

        if (i_cfg.load) begin
            n_skip_left = i_cfg.skip_bits;
        end
    end

    assign mem_wr_en = wr_en && (wr_idx != '0);

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nodes_used <= USED_W'(1);
            r_dec_node   <= '0;
            r_skip_left  <= '0;
            r_err_stop   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_root       <= '0;
        end else begin
            r_state      <= n_state;
            r_nodes_used <= n_nodes_used;
            r_dec_node   <= n_dec_node;
            r_skip_left  <= n_skip_left;
            r_err_stop   <= n_err_stop;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_root       <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_bits     <= n_bits;
        r_sym      <= n_sym;
        r_byte     <= n_byte;
        r_bitcnt   <= n_bitcnt;
        r_pend_sym <= n_pend_sym;
        r_pend_st  <= n_pend_st;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used != '0) && (r_nodes_used <= NODE_LIMIT))
        else $error("node count out of range");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_stop |=> r_err_stop)
        else $error("error stop cleared without reset");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("result left pending at end of transaction");

    a_dec_node_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        USED_W'(r_dec_node) < r_nodes_used)
        else $error("decode position points at unallocated node");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == htsd_pkg::ST_FULL)) |-> (r_nodes_used == NODE_LIMIT))
        else $error("store full reported with free nodes");
`endif

endmodule

`default_nettype wire

>>> rtl/huffman_tree_stream_decoder.sv
`default_nettype none

// Huffman tree builder and bitstream decoder. Load transactions (func 0) walk a
// code from its most significant bit, allocate missing tree nodes and write the
// symbol at the end node; a full node store returns one result with status 2.
// Decode transactions (func 1) feed one payload byte, MSB first: the first
// skip_bits payload bits are dropped, then each bit steps left (0) or right (1)
// and every leaf reached returns its symbol; a missing child returns status 1
// and blocks all later decode transactions until reset (loads still work). With
// an empty root each payload bit returns the root symbol. The last result of a
// transaction carries last = 1. Structure: a front end classifies transactions
// into a four-entry queue, so input keeps flowing while the back end works, until
// the queue fills. The back end uses a single node memory with a registered read:
// a load writes each newly allocated node without a read, reads each existing node
// on the path before it steps on, and ends with the symbol write; a decode byte
// handles skipped and single-symbol bits without a read, reads each node it steps
// to, may fetch the saved position first, and ends by flushing any held result.
// Nodes are initialized as they are allocated, so no clearing pass runs after
// reset. skip_bits (address 0) also reloads the skip counter when written and
// should only be written while the block is idle.
module huffman_tree_stream_decoder #(
    parameter int NODE_COUNT   = 511,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    htsd_stream_if.sink                              i_item,
    htsd_stream_if.source                            o_result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [htsd_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [htsd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [htsd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    // Configuration register
    logic [htsd_pkg::SYM_W-1:0] r_skip_bits, n_skip_bits;
    logic                       cfg_wr;
    htsd_pkg::t_cfg             cfg;

    // Front to back queue interface
    logic                       cmd_valid;
    htsd_pkg::t_cmd             cmd;
    logic                       cmd_pop;

    // Result stage
    logic                       out_valid;
    htsd_pkg::t_out_item        out_item;

    assign pready = 1'b1;
    // register index is paddr[2]; the low address bits are ignored
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == htsd_pkg::REG_SKIP_BITS);

    assign n_skip_bits   = cfg_wr ? pwdata[htsd_pkg::SYM_W-1:0] : r_skip_bits;
    assign cfg.load      = cfg_wr;
    assign cfg.skip_bits = pwdata[htsd_pkg::SYM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_bits <= '0;
        end else begin
            r_skip_bits <= n_skip_bits;
        end
    end

    assign prdata = (paddr[2] == htsd_pkg::REG_SKIP_BITS) ?
                    (htsd_pkg::APB_DATA_W)'(r_skip_bits) : '0;

    // Front: accepts transactions, saturates the code length, queues commands
    htsd_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_item.valid),
        .o_ready     (i_item.ready),
        .i_data      (i_item.data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: tree build and bit-serial decode over the node memory
    htsd_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (cfg),
        .o_out_valid (out_valid),
        .o_out       (out_item),
        .i_out_ready (o_result.ready)
    );

    assign o_result.valid = out_valid;
    assign o_result.data  = out_item;

endmodule

`default_nettype wire

>>> test/tb_huffman_tree_stream_decoder.sv
`timescale 1ns / 100ps

// Testbench for huffman_tree_stream_decoder.
// Flow:
//   1. Opening table: decode with an empty root, a zero-length code for the
//      root symbol, skip_bits counts, a small complete code tree, and a symbol
//      on an inner node, which is stored but never decoded.
//   2. Random phases with a new skip_bits value in each. The code tree always
//      stays complete, so random bytes never hit a missing branch. Loads either
//      rewrite symbols (leaf, inner node or root) or split a leaf into two leaves.
//   3. Closing: long codes, some longer than the 32-bit limit, fill the node
//      store. A load that finds no free node reports "table full". Random bytes
//      then run into a missing branch. After that, decode is halted for the
//      rest of the run.
// Every accepted transaction runs through a local tree model. Results must
// arrive in order and match the expected values (model or table) field by field.
module tb_huffman_tree_stream_decoder;

    localparam int NODE_COUNT     = 511;
    localparam int MAX_CODE_LEN   = 32;
    localparam int RANDOM_ITEMS   = 480;
    localparam int MAX_LEAF_LEN   = 24;    // keeps random codes well inside the depth limit
    localparam int SPLIT_NODE_CAP = 380;   // leave room for the fill pass at the end
    localparam int DRAIN_CYCLES   = 400;   // drain time for up to 5 loads in flight
    localparam int CYCLE_LIMIT    = 600000;

    localparam logic [htsd_pkg::APB_ADDR_W-1:0] ADDR_SKIP_BITS =
        {htsd_pkg::REG_SKIP_BITS, 2'b00};

    typedef enum logic [1:0] {ROW_LOAD, ROW_DATA, ROW_CFG} t_row_kind;

    // n_typed < 0: results come from the model. Otherwise n_typed results,
    // each typed_sym / typed_st, with last set on the final one.
    typedef struct {
        t_row_kind          kind;
        htsd_pkg::t_in_item item;    // for ROW_CFG, data_byte carries the register value
        int                 n_typed;
        logic [7:0]         typed_sym;
        logic [1:0]         typed_st;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [htsd_pkg::APB_ADDR_W-1:0] paddr;
    logic [htsd_pkg::APB_DATA_W-1:0] pwdata;
    logic [htsd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    htsd_stream_if #(.t_payload(htsd_pkg::t_in_item))  item_if ();
    htsd_stream_if #(.t_payload(htsd_pkg::t_out_item)) res_if ();

    huffman_tree_stream_decoder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Tree model state
    // ---------------------------------------------------------------------
    logic [8:0]  tree_left  [NODE_COUNT];
    logic [8:0]  tree_right [NODE_COUNT];
    logic [1:0]  tree_links [NODE_COUNT];   // bit 0 left child present, bit 1 right
    logic [7:0]  tree_sym   [NODE_COUNT];
    int unsigned node_total;
    logic [8:0]  walk_node;
    logic [7:0]  skip_remaining;
    bit          decode_halted;

    htsd_pkg::t_out_item step_results[$];      // results of the latest transaction
    htsd_pkg::t_out_item pending_results[$];   // expected, oldest first

    int          err_count   = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          items_sent  = 0;

    // Leaves of the complete code tree that the random phases keep
    int unsigned leaf_code[$];
    int unsigned leaf_len[$];

    t_stim_row   opening_rows[$];

    // Model of one transaction; fills step_results.
    function automatic void tree_model_step(input htsd_pkg::t_in_item it);
        int unsigned         len;
        int unsigned         j;
        int                  i;
        logic [8:0]          node;
        logic [8:0]          nxt;
        logic                b;
        htsd_pkg::t_out_item r;
        step_results.delete();
        if (it.func == htsd_pkg::FUNC_LOAD) begin
            len  = 32'(it.code_len);
            if (len > MAX_CODE_LEN) len = MAX_CODE_LEN;
            node = '0;
            for (j = len; j > 0; j--) begin
                b = it.code_bits[j-1];
                if (tree_links[node][b]) begin
                    nxt = b ? tree_right[node] : tree_left[node];
                end else if (node_total >= NODE_COUNT) begin
                    // Store full: nodes allocated so far stay, the symbol is dropped
                    r.out_symbol = '0;
                    r.status     = htsd_pkg::ST_FULL;
                    r.last       = 1'b1;
                    step_results.push_back(r);
                    return;
                end else begin
                    nxt = 9'(node_total);
                    node_total++;
                    tree_links[nxt] = 2'b00;
                    tree_sym[nxt]   = '0;
                    if (b) tree_right[node] = nxt;
                    else   tree_left[node]  = nxt;
                    tree_links[node][b] = 1'b1;
                end
                node = nxt;
            end
            tree_sym[node] = it.code_symbol;
        end else if (!decode_halted) begin
            for (i = 7; i >= 0; i--) begin
                b = it.data_byte[i];
                r.last = 1'b0;
                if (skip_remaining != 0) begin
                    skip_remaining--;
                end else if (tree_links[0] == 2'b00) begin
                    // Empty root: every payload bit gives the root symbol
                    r.out_symbol = tree_sym[0];
                    r.status     = htsd_pkg::ST_SYMBOL;
                    step_results.push_back(r);
                end else if (!tree_links[walk_node][b]) begin
                    r.out_symbol  = '0;
                    r.status      = htsd_pkg::ST_INVALID;
                    step_results.push_back(r);
                    decode_halted = 1'b1;
                    walk_node     = '0;
                    break;
                end else begin
                    nxt = b ? tree_right[walk_node] : tree_left[walk_node];
                    if (tree_links[nxt] == 2'b00) begin
                        r.out_symbol = tree_sym[nxt];
                        r.status     = htsd_pkg::ST_SYMBOL;
                        step_results.push_back(r);
                        walk_node = '0;
                    end else begin
                        walk_node = nxt;
                    end
                end
            end
            if (step_results.size() != 0) step_results[step_results.size()-1].last = 1'b1;
        end
    endfunction

    function automatic htsd_pkg::t_in_item make_item(input logic func, input logic [7:0] sym,
                                                     input logic [5:0] len,
                                                     input logic [31:0] bits,
                                                     input logic [7:0] dbyte);
        htsd_pkg::t_in_item it;
        it.func        = func;
        it.code_symbol = sym;
        it.code_len    = len;
        it.code_bits   = bits;
        it.data_byte   = dbyte;
        return it;
    endfunction

    // Table rows. Fields the block ignores get random noise.
    function automatic t_stim_row ld(input logic [7:0] sym, input logic [5:0] len,
                                     input logic [31:0] bits);
        t_stim_row r;
        r.kind      = ROW_LOAD;
        r.item      = make_item(htsd_pkg::FUNC_LOAD, sym, len, bits, 8'($urandom));
        r.n_typed   = -1;
        r.typed_sym = '0;
        r.typed_st  = htsd_pkg::ST_SYMBOL;
        return r;
    endfunction

    function automatic t_stim_row dt(input logic [7:0] dbyte, input int n_typed = -1,
                                     input logic [7:0] typed_sym = 8'h00);
        t_stim_row r;
        r.kind      = ROW_DATA;
        r.item      = make_item(htsd_pkg::FUNC_DECODE, 8'($urandom), 6'($urandom),
                                $urandom, dbyte);
        r.n_typed   = n_typed;
        r.typed_sym = typed_sym;
        r.typed_st  = htsd_pkg::ST_SYMBOL;
        return r;
    endfunction

    function automatic t_stim_row cf(input logic [7:0] val);
        t_stim_row r;
        r.kind      = ROW_CFG;
        r.item      = make_item(htsd_pkg::FUNC_LOAD, '0, '0, '0, val);
        r.n_typed   = -1;
        r.typed_sym = '0;
        r.typed_st  = htsd_pkg::ST_SYMBOL;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Sender: bursts of transactions separated by random gaps
    // ---------------------------------------------------------------------
    task automatic send_item(input htsd_pkg::t_in_item it, input bit typed_row = 1'b0);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        // Accepted at this edge
        burst_left--;
        items_sent++;
        tree_model_step(it);
        if (!typed_row) begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end
    endtask

    // Wait for the block to go idle: all results are in, and transactions that
    // give no result have also left the queue.
    task automatic settle();
        item_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_skip(input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SKIP_BITS;
        pwdata  <= htsd_pkg::APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Writing the register also reloads the skip counter
        skip_remaining = val;
    endtask

    task automatic run_row(input t_stim_row r);
        htsd_pkg::t_out_item e;
        if (r.kind == ROW_CFG) begin
            settle();
            write_skip(r.item.data_byte);
        end else begin
            send_item(r.item, r.n_typed >= 0);
            for (int k = 0; k < r.n_typed; k++) begin
                e.out_symbol = r.typed_sym;
                e.status     = r.typed_st;
                e.last       = (k == r.n_typed - 1);
                pending_results.push_back(e);
            end
        end
    endtask

    // Load a code. Bits above the code length carry noise.
    task automatic load_code(input logic [7:0] sym, input int unsigned len,
                             input int unsigned code);
        logic [31:0] mask;
        mask = (32'd1 << len) - 32'd1;
        send_item(make_item(htsd_pkg::FUNC_LOAD, sym, 6'(len), ($urandom & ~mask) | code,
                            8'($urandom)));
    endtask

    // ---------------------------------------------------------------------
    // Receiver: checks results; ready follows modes of random length
    // (always ready, about half the time, rarely)
    // ---------------------------------------------------------------------
    initial begin
        int unsigned         mode;
        int unsigned         mode_left;
        htsd_pkg::t_out_item got;
        htsd_pkg::t_out_item want;
        res_if.ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, %s %0h %s %0h %s %0h",
                             $time, "actual symbol", got.out_symbol, "status", got.status,
                             "last", got.last);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_symbol", want.out_symbol, got.out_symbol);
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("last", 8'(want.last), 8'(got.last));
                end
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= 1'($urandom_range(0, 1));
                default: res_if.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
            $display("tb_huffman_tree_stream_decoder: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        t_stim_row   r;
        int          random_start;
        int          phase_left;
        int          phase_idx;
        int unsigned pick;
        int unsigned li;
        int unsigned c;
        int unsigned l;
        int unsigned k;
        logic [7:0]  skip_val;
        int          tries;

        i_rst_n       <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        // Model state after reset: root only, everything cleared
        for (int n = 0; n < NODE_COUNT; n++) begin
            tree_left[n]  = '0;
            tree_right[n] = '0;
            tree_links[n] = 2'b00;
            tree_sym[n]   = '0;
        end
        node_total     = 1;
        walk_node      = '0;
        skip_remaining = '0;
        decode_halted  = 1'b0;

        // Opening table. Codes are given as {length, value}.
        opening_rows.push_back(dt(8'h00, 8, 8'h00));        // empty root, reset symbol
        opening_rows.push_back(ld(8'hFF, 6'd0, 32'hFFFF_FFFF)); // zero length sets the root symbol
        opening_rows.push_back(dt(8'hFF, 8, 8'hFF));
        opening_rows.push_back(cf(8'd3));
        opening_rows.push_back(dt(8'h5A, 5, 8'hFF));        // first 3 bits skipped
        opening_rows.push_back(cf(8'd12));
        opening_rows.push_back(dt(8'h00, 0));                // whole byte skipped
        opening_rows.push_back(dt(8'h0F, 4, 8'hFF));
        opening_rows.push_back(cf(8'd0));
        opening_rows.push_back(ld(8'h11, 6'd1, 32'hFFFF_FFFE)); // "0", noise above ignored
        opening_rows.push_back(ld(8'h22, 6'd2, 32'hFFFF_FFFE)); // "10"
        opening_rows.push_back(ld(8'h33, 6'd2, 32'h0000_0003)); // "11"
        opening_rows.push_back(dt(8'h00, 8, 8'h11));
        opening_rows.push_back(ld(8'h44, 6'd1, 32'h0000_0001)); // inner node "1": never decoded
        opening_rows.push_back(dt(8'hFF, 4, 8'h33));
        opening_rows.push_back(dt(8'hA5));
        opening_rows.push_back(ld(8'h00, 6'd0, 32'h0000_0000)); // root symbol, now hidden
        // Split leaf "11" into "110" / "111" in two transactions back to back
        opening_rows.push_back(ld(8'hFF, 6'd3, 32'h0000_0006));
        opening_rows.push_back(ld(8'h00, 6'd3, 32'hFFFF_FFFF));
        opening_rows.push_back(dt(8'hFF));
        opening_rows.push_back(dt(8'h00));

        // Leaves that the table above leaves in place
        leaf_code = '{0, 2, 6, 7};
        leaf_len  = '{1, 2, 3, 3};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[n]) run_row(opening_rows[n]);

        // Random phases: the tree stays complete, so any byte decodes
        random_start = items_sent;
        phase_left   = $urandom_range(30, 60);
        phase_idx    = 0;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            if (phase_left <= 0) begin
                settle();
                phase_idx++;
                case (phase_idx)
                    1:       skip_val = 8'd255;
                    2:       skip_val = 8'd0;
                    default: skip_val = $urandom_range(0, 1) ? 8'($urandom_range(0, 16))
                                                             : 8'($urandom);
                endcase
                write_skip(skip_val);
                phase_left = $urandom_range(30, 60);
            end
            pick = $urandom_range(0, 99);
            li   = $urandom_range(0, leaf_len.size() - 1);
            c    = leaf_code[li];
            l    = leaf_len[li];
            if (pick < 70) begin
                send_item(make_item(htsd_pkg::FUNC_DECODE, 8'($urandom), 6'($urandom),
                                    $urandom, 8'($urandom)));
            end else if (pick < 82) begin
                load_code(8'($urandom), l, c);              // new symbol on a leaf
            end else if (pick < 88) begin
                k = $urandom_range(1, l);                   // inner node or root symbol
                load_code(8'($urandom), l - k, c >> k);
            end else if (node_total < SPLIT_NODE_CAP && l < MAX_LEAF_LEN) begin
                // Leaf becomes two leaves; both loads go in back to back
                leaf_code.delete(li);
                leaf_len.delete(li);
                load_code(8'($urandom), l + 1, c << 1);
                load_code(8'($urandom), l + 1, (c << 1) | 1);
                leaf_code.push_back(c << 1);
                leaf_len.push_back(l + 1);
                leaf_code.push_back((c << 1) | 1);
                leaf_len.push_back(l + 1);
            end else begin
                send_item(make_item(htsd_pkg::FUNC_DECODE, 8'($urandom), 6'($urandom),
                                    $urandom, 8'($urandom)));
            end
            phase_left--;
        end

        settle();
        write_skip(8'd0);

        // Fill the store with long codes, lengths 32..63 (saturated). Odd
        // values keep the all-zero path at depth 32 unallocated.
        while (node_total < NODE_COUNT) begin
            send_item(make_item(htsd_pkg::FUNC_LOAD, 8'($urandom),
                                6'($urandom_range(32, 63)), $urandom | 32'd1,
                                8'($urandom)));
        end
        r           = ld(8'hAB, 6'd32, 32'h0000_0000);
        r.n_typed   = 1;
        r.typed_sym = 8'h00;
        r.typed_st  = htsd_pkg::ST_FULL;
        run_row(r);

        // The fill left single-child nodes, so random bytes soon hit a missing branch
        tries = 0;
        while (!decode_halted && tries < 64) begin
            send_item(make_item(htsd_pkg::FUNC_DECODE, 8'($urandom), 6'($urandom),
                                $urandom, 8'($urandom)));
            tries++;
        end
        // Halted: decode gives nothing, loads are still accepted
        run_row(dt(8'hFF));
        run_row(ld(8'h5C, 6'd1, 32'h0000_0000));
        run_row(dt(8'h00));

        settle();
        if (err_count == 0) begin
            $display("tb_huffman_tree_stream_decoder: PASS");
        end else begin
            $display("tb_huffman_tree_stream_decoder: FAIL");
        end
        $finish;
    end

endmodule
